### rtl/core/scpc_pkg.sv
// Shared types and constants for the sample clock phase centering block.
package scpc_pkg;

	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 18;
	localparam int PATTERN_W     = 18;
	localparam int HYST_W        = 8;
	localparam int STEP_W        = 10;

	localparam logic [CFG_INDEX_W-1:0] CFG_TEST_PATTERN     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP       = 2'd2;

	localparam logic [PATTERN_W-1:0] TEST_PATTERN_RST     = 18'b110011000011111100;
	localparam logic [HYST_W-1:0]    HYSTERESIS_COUNT_RST = 8'd10;
	localparam logic [STEP_W-1:0]    PHASE_STEP_RST       = 10'd10;

	localparam logic FUNC_START  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_SEEK_BAD  = 5'b00010,
		ST_SEEK_GOOD = 5'b00100,
		ST_SEEK_END  = 5'b01000,
		ST_VERIFY    = 5'b10000
	} stage_t;

	typedef struct packed {
		logic [PATTERN_W-1:0] test_pattern;
		logic [HYST_W-1:0]    hysteresis_count;
		logic [STEP_W-1:0]    phase_step;
	} cfg_regs_t;

	typedef struct packed {
		logic shift_valid;
		logic busy;
		logic done;
		logic pass;
	} res_flags_t;

endpackage

### rtl/core/scpc_if.sv
// Channel interfaces for sample words, result words and configuration writes.
interface scpc_sample_if #(
	parameter int SAMPLE_BITS = 18
);
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [SAMPLE_BITS-1:0] lane0_word;
	logic [SAMPLE_BITS-1:0] lane1_word;

	modport source (output valid, func, lane0_word, lane1_word, input ready);
	modport sink   (input valid, func, lane0_word, lane1_word, output ready);
endinterface

interface scpc_result_if #(
	parameter int PHASE_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic                         shift_valid;
	logic signed [PHASE_BITS-1:0] shift_amount;
	logic                         busy_res;
	logic                         done_res;
	logic                         pass;
	logic signed [PHASE_BITS-1:0] phase_now;
	logic signed [PHASE_BITS-1:0] window_width;

	modport source (output valid, shift_valid, shift_amount, busy_res, done_res, pass,
		phase_now, window_width, input ready);
	modport sink   (input valid, shift_valid, shift_amount, busy_res, done_res, pass,
		phase_now, window_width, output ready);
endinterface

interface scpc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [scpc_pkg::CFG_INDEX_W-1:0] index;
	logic [scpc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/sample_clock_phase_centering.sv
// Top level of the sample clock phase centering block: channels, registers and result stage.
//
//  channel  dir  payload                                              handshake
//  sample   in   func, lane0_word, lane1_word                         valid/ready
//  result   out  shift_valid, shift_amount, busy_res, done_res, pass,  valid/ready
//                phase_now, window_width
//  cfg      in   index, data                                          valid/ready, ready high
//
// One word per cycle is accepted while the result channel does not stall; each sample word
// passes through the input register and then the result register around the search logic.
// arst_n clears the search state and loads the register defaults.
// A stalled result holds in the result register while one more word waits in the input
// register; the sample channel drops ready only when both are full.
module sample_clock_phase_centering
	import scpc_pkg::*;
#(
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	scpc_sample_if.sink sample,
	scpc_result_if.source result,
	scpc_cfg_if.sink    cfg
);

	cfg_regs_t cfg_regs_q;

	logic                   valid_s1;
	logic                   func_s1;
	logic [SAMPLE_BITS-1:0] lane0_s1;
	logic [SAMPLE_BITS-1:0] lane1_s1;

	logic                  res_valid_q;
	res_flags_t            res_flags_q;
	logic [PHASE_BITS-1:0] res_amount_q;
	logic [PHASE_BITS-1:0] res_phase_q;
	logic [PHASE_BITS-1:0] res_width_q;

	res_flags_t            flags;
	logic [PHASE_BITS-1:0] shift_amount;
	logic [PHASE_BITS-1:0] phase_now;
	logic [PHASE_BITS-1:0] window_width;
	logic                  advance;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.test_pattern     <= TEST_PATTERN_RST;
			cfg_regs_q.hysteresis_count <= HYSTERESIS_COUNT_RST;
			cfg_regs_q.phase_step       <= PHASE_STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TEST_PATTERN:     cfg_regs_q.test_pattern     <= PATTERN_W'(cfg.data);
				CFG_HYSTERESIS_COUNT: cfg_regs_q.hysteresis_count <= HYST_W'(cfg.data);
				CFG_PHASE_STEP:       cfg_regs_q.phase_step       <= STEP_W'(cfg.data);
				default: begin
				end
			endcase
		end
	end

	// The word in the input register moves on whenever the result register is free or drains.
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			func_s1  <= sample.func;
			lane0_s1 <= sample.lane0_word;
			lane1_s1 <= sample.lane1_word;
		end
	end

	scpc_search #(
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.func         (func_s1),
		.lane0_word   (lane0_s1),
		.lane1_word   (lane1_s1),
		.cfg_regs     (cfg_regs_q),
		.flags        (flags),
		.shift_amount (shift_amount),
		.phase_now    (phase_now),
		.window_width (window_width)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_flags_q  <= flags;
			res_amount_q <= shift_amount;
			res_phase_q  <= phase_now;
			res_width_q  <= window_width;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.shift_valid  = res_flags_q.shift_valid;
	assign result.shift_amount = $signed(res_amount_q);
	assign result.busy_res     = res_flags_q.busy;
	assign result.done_res     = res_flags_q.done;
	assign result.pass         = res_flags_q.pass;
	assign result.phase_now    = $signed(res_phase_q);
	assign result.window_width = $signed(res_width_q);

	a_pass_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_flags_q.done |-> !res_flags_q.pass)
		else $error("pass set on a word that does not finish verification");

	a_no_amount_without_shift: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_flags_q.shift_valid |-> res_amount_q == '0)
		else $error("shift amount nonzero without a shift command");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_flags_q.done |-> !res_flags_q.busy && !res_flags_q.shift_valid)
		else $error("verification word still busy or shifting");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register empty after a word moved into it");

endmodule

### rtl/core/scpc_search.sv
// Search state and combinational next-state logic for the eye centering sequence.
module scpc_search
	import scpc_pkg::*;
#(
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step_en,
	input  logic                   func,
	input  logic [SAMPLE_BITS-1:0] lane0_word,
	input  logic [SAMPLE_BITS-1:0] lane1_word,
	input  cfg_regs_t              cfg_regs,
	output res_flags_t             flags,
	output logic [PHASE_BITS-1:0]  shift_amount,
	output logic [PHASE_BITS-1:0]  phase_now,
	output logic [PHASE_BITS-1:0]  window_width
);

	stage_t                stage_q, stage_n;
	logic [HYST_W-1:0]     run_left_q, run_left_n;
	logic [PHASE_BITS-1:0] open_q, open_n;
	logic [PHASE_BITS-1:0] close_q, close_n;
	logic [PHASE_BITS-1:0] phase_q, phase_n;

	logic [SAMPLE_BITS-1:0] pattern;
	logic                   good;
	logic [HYST_W-1:0]      hyst;
	logic [PHASE_BITS-1:0]  step_amt;
	logic [PHASE_BITS:0]    mid_sum;
	logic [PHASE_BITS:0]    mid_adj;
	logic [PHASE_BITS-1:0]  amount;
	logic                   shift;

	assign pattern  = SAMPLE_BITS'(cfg_regs.test_pattern);
	assign good     = (lane0_word == pattern) && (lane1_word == pattern);
	assign hyst     = (cfg_regs.hysteresis_count == '0) ? HYST_W'(1) : cfg_regs.hysteresis_count;
	assign step_amt = PHASE_BITS'(cfg_regs.phase_step);

	// Signed midpoint of the window; adding the sign bit before the shift rounds toward zero.
	assign mid_sum = {open_n[PHASE_BITS-1], open_n} + {close_n[PHASE_BITS-1], close_n};
	assign mid_adj = mid_sum + {{PHASE_BITS{1'b0}}, mid_sum[PHASE_BITS]};

	always_comb begin
		stage_n    = stage_q;
		run_left_n = run_left_q;
		open_n     = open_q;
		close_n    = close_q;
		shift      = 1'b0;
		amount     = '0;
		flags      = '0;
		if (func == FUNC_START) begin
			stage_n    = ST_SEEK_BAD;
			run_left_n = hyst;
			open_n     = '0;
			close_n    = '0;
			shift      = 1'b1;
			amount     = step_amt;
		end else begin
			unique case (stage_q)
				ST_SEEK_BAD: begin
					run_left_n = good ? hyst : run_left_q - HYST_W'(1);
					if (run_left_n == '0) begin
						stage_n    = ST_SEEK_GOOD;
						run_left_n = hyst;
					end
					shift  = 1'b1;
					amount = step_amt;
				end
				ST_SEEK_GOOD: begin
					if (good) begin
						if (run_left_q == hyst) begin
							open_n = phase_q;
						end
						run_left_n = run_left_q - HYST_W'(1);
					end else begin
						run_left_n = hyst;
					end
					if (run_left_n == '0) begin
						stage_n    = ST_SEEK_END;
						run_left_n = hyst;
					end
					shift  = 1'b1;
					amount = step_amt;
				end
				ST_SEEK_END: begin
					if (!good) begin
						if (run_left_q == hyst) begin
							close_n = phase_q;
						end
						run_left_n = run_left_q - HYST_W'(1);
					end else begin
						run_left_n = hyst;
					end
					shift = 1'b1;
					if (run_left_n == '0) begin
						stage_n = ST_VERIFY;
						amount  = mid_adj[PHASE_BITS:1] - phase_q;
					end else begin
						amount = step_amt;
					end
				end
				ST_VERIFY: begin
					flags.done = 1'b1;
					flags.pass = good;
					stage_n    = ST_IDLE;
					run_left_n = '0;
				end
				default: begin
				end
			endcase
		end
		phase_n           = shift ? phase_q + amount : phase_q;
		flags.shift_valid = shift;
		flags.busy        = (stage_n != ST_IDLE);
	end

	assign shift_amount = amount;
	assign phase_now    = phase_n;
	assign window_width = close_n - open_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q    <= ST_IDLE;
			run_left_q <= '0;
			open_q     <= '0;
			close_q    <= '0;
			phase_q    <= '0;
		end else if (step_en) begin
			stage_q    <= stage_n;
			run_left_q <= run_left_n;
			open_q     <= open_n;
			close_q    <= close_n;
			phase_q    <= phase_n;
		end
	end

endmodule
